// ===== rtl/cfa_pkg.sv =====
// Shared types and constants of the coarse face agglomerator.
// No dependencies; used by the controller, the datapath, the top level and the testbench.
package cfa_pkg;

    localparam int FINE_W    = 12;   // fine cell number
    localparam int COARSE_W  = 10;   // coarse cell number
    localparam int NCC_W     = 11;   // coarse cell count register
    localparam int FFACE_W   = 14;   // fine face index / face map
    localparam int CFACE_W   = 13;   // coarse face index
    localparam int NCNT_W    = 5;    // neighbour count, 0..16
    localparam int NSLOT_W   = 4;    // neighbour slot index

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_ADD   = 3'd2;
    localparam logic [2:0] ACT_FIN   = 3'd3;
    localparam logic [2:0] ACT_RDC   = 3'd4;
    localparam logic [2:0] ACT_RDF   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CELL  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DONE, S_DECODE, S_CLR,
        S_A_L, S_A_CL, S_A_CHK, S_A_CNT, S_A_SL, S_A_SW, S_A_CMP,
        S_F_CNT, S_F_CNTC, S_F_SL, S_F_SW, S_F_WR,
        S_R4, S_R5A, S_R5B
    } t_state;

    typedef enum logic [4:0] {
        UOP_NONE, UOP_LATCH, UOP_DECODE, UOP_CLR_STEP,
        UOP_RD_L, UOP_CAP_L, UOP_A_CHK, UOP_CNT,
        UOP_SLOT_RD, UOP_SLOT_CAP, UOP_CMP, UOP_NEW,
        UOP_F_CNT_RD, UOP_F_SL_RD, UOP_F_WR, UOP_F_NEXTC, UOP_F_END,
        UOP_CAP4, UOP_CAP5A, UOP_CAP5B
    } t_uop;

    typedef struct packed {
        logic       reject;
        logic [2:0] action;
        logic       cells_ok;
        logic       same_cell;
        logic       srch_end;
        logic       hit;
        logic       clr_last;
        logic       c_last;
    } t_dp_stat;

endpackage

// ===== rtl/coarse_face_agglomerator_unit.sv =====
// Coarse face agglomerator top level: controller plus datapath.
// Depends on cfa_pkg, cfa_ctrl and cfa_datapath.
//
// Load, reject and bad-order words finish at decode; clear sweeps map and counts.
// Add face: stops at the check when a cell is unmapped or the face internal; else it
//   scans list entries to a hit or the list end; single-port slot and neighbour reads.
// Finalize: walks all 1024 owner lists and numbers the coarse faces in owner order.
// One word in flight; start is taken whenever busy is low, also in the o_valid cycle.
// Reset: synchronous, active low; a sweep then clears map and counts, busy high.
module coarse_face_agglomerator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_wdata,
    input  logic [2:0]          i_action,
    input  logic [11:0]         i_fine_cell,
    input  logic [9:0]          i_coarse_cell,
    input  logic [11:0]         i_upper_cell,
    input  logic [11:0]         i_lower_cell,
    input  logic [13:0]         i_read_index,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [13:0]         o_coarse_face_count,
    output logic [9:0]          o_face_owner,
    output logic [9:0]          o_face_neighbour,
    output logic signed [13:0]  o_face_map,
    output logic                o_flip
);

    cfa_pkg::t_uop     uop;
    cfa_pkg::t_dp_stat stat;

    // sequencer: one micro-op per cycle
    cfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_uop   (uop),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // memories and working registers; result fields are registered here
    cfa_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_uop               (uop),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_action            (i_action),
        .i_fine_cell         (i_fine_cell),
        .i_coarse_cell       (i_coarse_cell),
        .i_upper_cell        (i_upper_cell),
        .i_lower_cell        (i_lower_cell),
        .i_read_index        (i_read_index),
        .o_stat              (stat),
        .o_status            (o_status),
        .o_coarse_face_count (o_coarse_face_count),
        .o_face_owner        (o_face_owner),
        .o_face_neighbour    (o_face_neighbour),
        .o_face_map          (o_face_map),
        .o_flip              (o_flip)
    );

endmodule

// ===== rtl/cfa_ctrl.sv =====
// Sequencer of the coarse face agglomerator: state machine issuing one
// micro-op per cycle to the datapath. Depends on cfa_pkg.
module cfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cfa_pkg::t_dp_stat i_stat,
    output cfa_pkg::t_uop     o_uop,
    output logic              o_busy,
    output logic              o_valid
);

    cfa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfa_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cfa_pkg::S_INIT: begin
                if (i_stat.clr_last) n_state = cfa_pkg::S_IDLE;
            end
            cfa_pkg::S_IDLE, cfa_pkg::S_DONE: begin
                if (i_start) n_state = cfa_pkg::S_DECODE;
                else n_state = cfa_pkg::S_IDLE;
            end
            cfa_pkg::S_DECODE: begin
                if (i_stat.reject) begin
                    n_state = cfa_pkg::S_DONE;
                end else begin
                    case (i_stat.action)
                        cfa_pkg::ACT_CLEAR: n_state = cfa_pkg::S_CLR;
                        cfa_pkg::ACT_ADD:   n_state = cfa_pkg::S_A_L;
                        cfa_pkg::ACT_FIN:   n_state = cfa_pkg::S_F_CNT;
                        cfa_pkg::ACT_RDC:   n_state = cfa_pkg::S_R4;
                        cfa_pkg::ACT_RDF:   n_state = cfa_pkg::S_R5A;
                        default:            n_state = cfa_pkg::S_DONE;
                    endcase
                end
            end
            cfa_pkg::S_CLR: begin
                if (i_stat.clr_last) n_state = cfa_pkg::S_DONE;
            end
            cfa_pkg::S_A_L:   n_state = cfa_pkg::S_A_CL;
            cfa_pkg::S_A_CL:  n_state = cfa_pkg::S_A_CHK;
            cfa_pkg::S_A_CHK: begin
                if (!i_stat.cells_ok || i_stat.same_cell) n_state = cfa_pkg::S_DONE;
                else n_state = cfa_pkg::S_A_CNT;
            end
            cfa_pkg::S_A_CNT: n_state = cfa_pkg::S_A_SL;
            cfa_pkg::S_A_SL: begin
                if (i_stat.srch_end) n_state = cfa_pkg::S_DONE;
                else n_state = cfa_pkg::S_A_SW;
            end
            cfa_pkg::S_A_SW:  n_state = cfa_pkg::S_A_CMP;
            cfa_pkg::S_A_CMP: begin
                if (i_stat.hit) n_state = cfa_pkg::S_DONE;
                else n_state = cfa_pkg::S_A_SL;
            end
            cfa_pkg::S_F_CNT:  n_state = cfa_pkg::S_F_CNTC;
            cfa_pkg::S_F_CNTC: n_state = cfa_pkg::S_F_SL;
            cfa_pkg::S_F_SL: begin
                if (!i_stat.srch_end) n_state = cfa_pkg::S_F_SW;
                else if (i_stat.c_last) n_state = cfa_pkg::S_DONE;
                else n_state = cfa_pkg::S_F_CNT;
            end
            cfa_pkg::S_F_SW: n_state = cfa_pkg::S_F_WR;
            cfa_pkg::S_F_WR: n_state = cfa_pkg::S_F_SL;
            cfa_pkg::S_R4:   n_state = cfa_pkg::S_DONE;
            cfa_pkg::S_R5A:  n_state = cfa_pkg::S_R5B;
            cfa_pkg::S_R5B:  n_state = cfa_pkg::S_DONE;
            default:         n_state = cfa_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_uop   = cfa_pkg::UOP_NONE;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            cfa_pkg::S_INIT, cfa_pkg::S_CLR: o_uop = cfa_pkg::UOP_CLR_STEP;
            cfa_pkg::S_IDLE, cfa_pkg::S_DONE: begin
                o_busy  = 1'b0;
                o_valid = (r_state == cfa_pkg::S_DONE);
                if (i_start) o_uop = cfa_pkg::UOP_LATCH;
            end
            cfa_pkg::S_DECODE: o_uop = cfa_pkg::UOP_DECODE;
            cfa_pkg::S_A_L:    o_uop = cfa_pkg::UOP_RD_L;
            cfa_pkg::S_A_CL:   o_uop = cfa_pkg::UOP_CAP_L;
            cfa_pkg::S_A_CHK:  o_uop = cfa_pkg::UOP_A_CHK;
            cfa_pkg::S_A_CNT:  o_uop = cfa_pkg::UOP_CNT;
            cfa_pkg::S_A_SL: begin
                if (i_stat.srch_end) o_uop = cfa_pkg::UOP_NEW;
                else o_uop = cfa_pkg::UOP_SLOT_RD;
            end
            cfa_pkg::S_A_SW:   o_uop = cfa_pkg::UOP_SLOT_CAP;
            cfa_pkg::S_A_CMP:  o_uop = cfa_pkg::UOP_CMP;
            cfa_pkg::S_F_CNT:  o_uop = cfa_pkg::UOP_F_CNT_RD;
            cfa_pkg::S_F_CNTC: o_uop = cfa_pkg::UOP_CNT;
            cfa_pkg::S_F_SL: begin
                if (!i_stat.srch_end) o_uop = cfa_pkg::UOP_F_SL_RD;
                else if (i_stat.c_last) o_uop = cfa_pkg::UOP_F_END;
                else o_uop = cfa_pkg::UOP_F_NEXTC;
            end
            cfa_pkg::S_F_SW:   o_uop = cfa_pkg::UOP_SLOT_CAP;
            cfa_pkg::S_F_WR:   o_uop = cfa_pkg::UOP_F_WR;
            cfa_pkg::S_R4:     o_uop = cfa_pkg::UOP_CAP4;
            cfa_pkg::S_R5A:    o_uop = cfa_pkg::UOP_CAP5A;
            cfa_pkg::S_R5B:    o_uop = cfa_pkg::UOP_CAP5B;
            default:           o_uop = cfa_pkg::UOP_NONE;
        endcase
    end

endmodule

// ===== rtl/cfa_datapath.sv =====
// Datapath of the coarse face agglomerator: map, neighbour list, face and
// renumbering memories plus working registers. Depends on cfa_pkg.
module cfa_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfa_pkg::t_uop         i_uop,
    input  logic                  i_cfg_we,
    input  logic [10:0]           i_cfg_wdata,
    input  logic [2:0]            i_action,
    input  logic [11:0]           i_fine_cell,
    input  logic [9:0]            i_coarse_cell,
    input  logic [11:0]           i_upper_cell,
    input  logic [11:0]           i_lower_cell,
    input  logic [13:0]           i_read_index,
    output cfa_pkg::t_dp_stat     o_stat,
    output logic [1:0]            o_status,
    output logic [13:0]           o_coarse_face_count,
    output logic [9:0]            o_face_owner,
    output logic [9:0]            o_face_neighbour,
    output logic signed [13:0]    o_face_map,
    output logic                  o_flip
);

    // memories
    logic [10:0] cmap_mem  [4096];
    logic [4:0]  ocnt_mem  [1024];
    logic [12:0] slot_mem  [16384];
    logic [9:0]  cnei_mem  [8192];
    logic [12:0] fpos_mem  [8192];
    logic [9:0]  fown_mem  [8192];
    logic [9:0]  fnei_mem  [8192];
    logic [13:0] ffm_mem   [16384];
    logic        fff_mem   [16384];

    logic [10:0] cmap_q;
    logic [4:0]  ocnt_q;
    logic [12:0] slot_q, fpos_q;
    logic [9:0]  cnei_q, fown_q, fnei_q;
    logic [13:0] ffm_q;
    logic        fff_q;

    // control registers
    logic [10:0] r_ncc, n_ncc;
    logic [13:0] r_faces, n_faces;
    logic [14:0] r_seen, n_seen;
    logic        r_final, n_final;
    logic [11:0] r_clr, n_clr;

    // payload registers
    logic [2:0]  r_action, n_action;
    logic [11:0] r_fine, n_fine, r_upper, n_upper, r_lower, n_lower;
    logic [9:0]  r_coarse, n_coarse;
    logic [13:0] r_rd, n_rd;
    logic [9:0]  r_cu, n_cu, r_cl, n_cl, r_own, n_own, r_nei, n_nei;
    logic        r_uok, n_uok, r_lok, n_lok, r_fl, n_fl;
    logic [4:0]  r_n, n_n, r_i, n_i;
    logic [12:0] r_s, n_s, r_k, n_k;
    logic [9:0]  r_c, n_c;
    logic [1:0]  r_status, n_status;
    logic signed [13:0] r_map, n_map;
    logic        r_flip, n_flip;
    logic [9:0]  r_fo, n_fo, r_fn, n_fn;

    logic [1:0]  dec_err;
    logic        cu_lt;
    logic [9:0]  own_c, nei_c;
    logic        new_ok, ff_we;

    // decode-time rejections
    always_comb begin
        dec_err = cfa_pkg::ST_OK;
        case (r_action)
            cfa_pkg::ACT_CLEAR: dec_err = cfa_pkg::ST_OK;
            cfa_pkg::ACT_LOAD: begin
                if (r_final) dec_err = cfa_pkg::ST_ORDER;
                else if ({1'b0, r_coarse} >= r_ncc) dec_err = cfa_pkg::ST_CELL;
            end
            cfa_pkg::ACT_ADD: begin
                if (r_final || r_seen[14]) dec_err = cfa_pkg::ST_ORDER;
            end
            cfa_pkg::ACT_FIN: begin
                if (r_final) dec_err = cfa_pkg::ST_ORDER;
            end
            cfa_pkg::ACT_RDC: begin
                if (!r_final || r_rd >= r_faces) dec_err = cfa_pkg::ST_ORDER;
            end
            cfa_pkg::ACT_RDF: begin
                if (!r_final || {1'b0, r_rd} >= r_seen) dec_err = cfa_pkg::ST_ORDER;
            end
            default: dec_err = cfa_pkg::ST_ORDER;
        endcase
    end

    assign cu_lt  = r_cu < r_cl;
    assign own_c  = cu_lt ? r_cu : r_cl;
    assign nei_c  = cu_lt ? r_cl : r_cu;
    assign new_ok = !r_n[4] && !r_faces[13];

    assign o_stat.reject    = (dec_err != cfa_pkg::ST_OK);
    assign o_stat.action    = r_action;
    assign o_stat.cells_ok  = r_uok && r_lok;
    assign o_stat.same_cell = (r_cu == r_cl);
    assign o_stat.srch_end  = (r_i == r_n);
    assign o_stat.hit       = (cnei_q == r_nei);
    assign o_stat.clr_last  = &r_clr;
    assign o_stat.c_last    = &r_c;

    // next register values
    always_comb begin
        n_ncc = r_ncc;     n_faces = r_faces; n_seen = r_seen;
        n_final = r_final; n_clr = r_clr;
        n_action = r_action; n_fine = r_fine; n_coarse = r_coarse;
        n_upper = r_upper; n_lower = r_lower; n_rd = r_rd;
        n_cu = r_cu; n_cl = r_cl; n_uok = r_uok; n_lok = r_lok;
        n_own = r_own; n_nei = r_nei; n_fl = r_fl;
        n_n = r_n; n_i = r_i; n_s = r_s; n_k = r_k; n_c = r_c;
        n_status = r_status; n_map = r_map; n_flip = r_flip;
        n_fo = r_fo; n_fn = r_fn;
        ff_we = 1'b0;
        if (i_cfg_we) n_ncc = i_cfg_wdata;
        case (i_uop)
            cfa_pkg::UOP_LATCH: begin
                n_action = i_action; n_fine = i_fine_cell; n_coarse = i_coarse_cell;
                n_upper = i_upper_cell; n_lower = i_lower_cell; n_rd = i_read_index;
                n_status = cfa_pkg::ST_OK; n_map = '0; n_flip = 1'b0;
                n_fo = '0; n_fn = '0;
            end
            cfa_pkg::UOP_DECODE: begin
                n_status = dec_err;
                if (dec_err == cfa_pkg::ST_OK) begin
                    if (r_action == cfa_pkg::ACT_CLEAR) begin
                        n_faces = '0; n_seen = '0; n_final = 1'b0; n_clr = '0;
                    end
                    if (r_action == cfa_pkg::ACT_FIN) begin
                        n_c = '0; n_k = '0;
                    end
                end
            end
            cfa_pkg::UOP_CLR_STEP: n_clr = r_clr + 12'd1;
            cfa_pkg::UOP_RD_L: begin
                n_cu  = cmap_q[9:0];
                n_uok = cmap_q[10] && ({1'b0, cmap_q[9:0]} < r_ncc);
            end
            cfa_pkg::UOP_CAP_L: begin
                n_cl  = cmap_q[9:0];
                n_lok = cmap_q[10] && ({1'b0, cmap_q[9:0]} < r_ncc);
            end
            cfa_pkg::UOP_A_CHK: begin
                if (!(r_uok && r_lok)) begin
                    n_status = cfa_pkg::ST_CELL;
                end else if (r_cu == r_cl) begin
                    n_map  = ~{4'b0, r_cu};      // -(cell+1)
                    n_flip = 1'b0;
                    n_seen = r_seen + 15'd1;
                    ff_we  = 1'b1;
                end else begin
                    n_own = own_c; n_nei = nei_c; n_fl = cu_lt;
                end
            end
            cfa_pkg::UOP_CNT: begin
                n_n = ocnt_q; n_i = '0;
            end
            cfa_pkg::UOP_SLOT_CAP: n_s = slot_q;
            cfa_pkg::UOP_CMP: begin
                if (cnei_q == r_nei) begin
                    n_map  = {1'b0, r_s};
                    n_flip = r_fl;
                    n_seen = r_seen + 15'd1;
                    ff_we  = 1'b1;
                end else begin
                    n_i = r_i + 5'd1;
                end
            end
            cfa_pkg::UOP_NEW: begin
                if (!new_ok) begin
                    n_status = cfa_pkg::ST_FULL;
                end else begin
                    n_map   = {1'b0, r_faces[12:0]};
                    n_flip  = r_fl;
                    n_faces = r_faces + 14'd1;
                    n_seen  = r_seen + 15'd1;
                    ff_we   = 1'b1;
                end
            end
            cfa_pkg::UOP_F_WR: begin
                n_k = r_k + 13'd1; n_i = r_i + 5'd1;
            end
            cfa_pkg::UOP_F_NEXTC: n_c = r_c + 10'd1;
            cfa_pkg::UOP_F_END:   n_final = 1'b1;
            cfa_pkg::UOP_CAP4: begin
                n_fo = fown_q; n_fn = fnei_q;
            end
            cfa_pkg::UOP_CAP5A: begin
                n_map = ffm_q; n_flip = fff_q;
            end
            cfa_pkg::UOP_CAP5B: begin
                if (!r_map[13]) n_map = {1'b0, fpos_q};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncc <= 11'd1; r_faces <= '0; r_seen <= '0; r_final <= 1'b0; r_clr <= '0;
        end else begin
            r_ncc <= n_ncc; r_faces <= n_faces; r_seen <= n_seen;
            r_final <= n_final; r_clr <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action; r_fine <= n_fine; r_coarse <= n_coarse;
        r_upper <= n_upper; r_lower <= n_lower; r_rd <= n_rd;
        r_cu <= n_cu; r_cl <= n_cl; r_uok <= n_uok; r_lok <= n_lok;
        r_own <= n_own; r_nei <= n_nei; r_fl <= n_fl;
        r_n <= n_n; r_i <= n_i; r_s <= n_s; r_k <= n_k; r_c <= n_c;
        r_status <= n_status; r_map <= n_map; r_flip <= n_flip;
        r_fo <= n_fo; r_fn <= n_fn;
    end

    // cell map: cleared by sweep, loaded by action 1
    always_ff @(posedge i_clk) begin
        if (i_uop == cfa_pkg::UOP_CLR_STEP) begin
            cmap_mem[r_clr] <= '0;
        end else if (i_uop == cfa_pkg::UOP_DECODE && r_action == cfa_pkg::ACT_LOAD
                     && dec_err == cfa_pkg::ST_OK) begin
            cmap_mem[r_fine] <= {1'b1, r_coarse};
        end
        cmap_q <= cmap_mem[(i_uop == cfa_pkg::UOP_RD_L) ? r_lower : r_upper];
    end

    // per-owner neighbour count
    always_ff @(posedge i_clk) begin
        if (i_uop == cfa_pkg::UOP_CLR_STEP) begin
            ocnt_mem[r_clr[9:0]] <= '0;
        end else if (i_uop == cfa_pkg::UOP_NEW && new_ok) begin
            ocnt_mem[r_own] <= r_n + 5'd1;
        end
        ocnt_q <= ocnt_mem[(i_uop == cfa_pkg::UOP_F_CNT_RD) ? r_c : own_c];
    end

    // neighbour list slots, owner-major
    always_ff @(posedge i_clk) begin
        if (i_uop == cfa_pkg::UOP_NEW && new_ok) begin
            slot_mem[{r_own, r_n[3:0]}] <= r_faces[12:0];
        end
        slot_q <= slot_mem[(i_uop == cfa_pkg::UOP_F_SL_RD) ? {r_c, r_i[3:0]}
                                                          : {r_own, r_i[3:0]}];
    end

    // neighbour of each created face, creation order
    always_ff @(posedge i_clk) begin
        if (i_uop == cfa_pkg::UOP_NEW && new_ok) begin
            cnei_mem[r_faces[12:0]] <= r_nei;
        end
        cnei_q <= cnei_mem[slot_q];
    end

    // renumbering and final-order face stores
    always_ff @(posedge i_clk) begin
        if (i_uop == cfa_pkg::UOP_F_WR) begin
            fpos_mem[r_s] <= r_k;
        end
        fpos_q <= fpos_mem[ffm_q[12:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_uop == cfa_pkg::UOP_F_WR) begin
            fown_mem[r_k] <= r_c;
            fnei_mem[r_k] <= cnei_q;
        end
        fown_q <= fown_mem[r_rd[12:0]];
        fnei_q <= fnei_mem[r_rd[12:0]];
    end

    // fine face records
    always_ff @(posedge i_clk) begin
        if (ff_we) begin
            ffm_mem[r_seen[13:0]] <= n_map;
            fff_mem[r_seen[13:0]] <= n_flip;
        end
        ffm_q <= ffm_mem[r_rd];
        fff_q <= fff_mem[r_rd];
    end

    assign o_status            = r_status;
    assign o_coarse_face_count = r_faces;
    assign o_face_owner        = r_fo;
    assign o_face_neighbour    = r_fn;
    assign o_face_map          = r_map;
    assign o_flip              = r_flip;

endmodule

// ===== rtl/cfa_checker.sv =====
// Port-level checks of the coarse face agglomerator, bound to the top level.
// Depends on coarse_face_agglomerator_unit.
module cfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [9:0]  o_face_owner,
    input logic [9:0]  o_face_neighbour,
    input logic [13:0] o_coarse_face_count
);

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result strobe while busy");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe repeated");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted word did not raise busy");

    a_face_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_face_owner < o_face_neighbour) || (o_face_neighbour == 10'd0))
        else $error("coarse face not upper triangular");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_coarse_face_count <= 14'd8192) else $error("face count too large");

endmodule

bind coarse_face_agglomerator_unit cfa_checker u_cfa_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for coarse_face_agglomerator_unit.
// Needs cfa_pkg and the RTL; directed table with typed-in replies first, then random
// agglomeration sessions checked against an in-bench face agglomeration predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_BAD6 = 3'd6;   // undefined actions
    localparam logic [2:0] ACT_BAD7 = 3'd7;
    localparam int N_FINE   = 4096;
    localparam int N_COARSE = 1024;
    localparam int N_FFACE  = 16384;
    localparam int N_CFACE  = 8192;
    localparam int N_NEIGH  = 16;
    localparam int STALL_LIMIT = 100000;     // well above the worst-case finalize run

    typedef struct packed {
        logic [2:0]  act;
        logic [11:0] fc;
        logic [9:0]  cc;
        logic [11:0] up;
        logic [11:0] lo;
        logic [13:0] idx;
    } t_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] count;
        logic [9:0]  owner;
        logic [9:0]  neigh;
        logic [13:0] fmap;
        logic        flip;
    } t_reply;

    typedef struct packed {
        t_word  w;
        logic   typed;   // 1: reply below is typed in, else predicted
        t_reply r;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_cfg_we = 0;
    logic [10:0] i_cfg_wdata = '0;
    logic [2:0]  i_action = '0;
    logic [11:0] i_fine_cell = '0;
    logic [9:0]  i_coarse_cell = '0;
    logic [11:0] i_upper_cell = '0;
    logic [11:0] i_lower_cell = '0;
    logic [13:0] i_read_index = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [13:0] o_coarse_face_count;
    logic [9:0]  o_face_owner;
    logic [9:0]  o_face_neighbour;
    logic signed [13:0] o_face_map;
    logic        o_flip;

    always #6 i_clk = ~i_clk;

    coarse_face_agglomerator_unit dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_wdata,
        .i_action, .i_fine_cell, .i_coarse_cell, .i_upper_cell,
        .i_lower_cell, .i_read_index, .o_valid, .o_status,
        .o_coarse_face_count, .o_face_owner, .o_face_neighbour,
        .o_face_map, .o_flip
    );

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the agglomerator.
    // ---------------------------------------------------------------
    int  ncc_reg;
    bit  map_valid [N_FINE];
    int  map_coarse [N_FINE];
    int  owner_cnt [N_COARSE];
    int  owner_slot [N_COARSE*N_NEIGH];
    int  cf_neigh [N_CFACE];
    int  cf_owner [N_CFACE];
    int  cf_final [N_CFACE];
    int  ff_map [N_FFACE];
    bit  ff_flip [N_FFACE];
    int  n_cfaces, n_ffaces;
    bit  is_final;

    t_reply replies_due[$];
    bit     failed = 0;
    int     n_words = 0;
    int     idle_pct = 0;

    function automatic void wipe_agglom();
        foreach (map_valid[i]) map_valid[i] = 0;
        foreach (owner_cnt[i]) owner_cnt[i] = 0;
        n_cfaces = 0;
        n_ffaces = 0;
        is_final = 0;
    endfunction

    function automatic int cell_lim();
        return (ncc_reg < N_COARSE) ? ncc_reg : N_COARSE;
    endfunction

    function automatic bit coarse_of(int fine, output int c);
        c = 0;
        if (!map_valid[fine] || map_coarse[fine] >= cell_lim()) return 0;
        c = map_coarse[fine];
        return 1;
    endfunction

    // adds one fine face; returns status, map and flip through outputs
    function automatic logic [1:0] agglomerate(int up, int lo, output int fm, output bit fl);
        int cu, cl, own, nei, n, f, i;
        bit hit;
        fm = 0;
        fl = 0;
        if (is_final || n_ffaces >= N_FFACE) return cfa_pkg::ST_ORDER;
        if (!coarse_of(up, cu) || !coarse_of(lo, cl)) return cfa_pkg::ST_CELL;
        if (cu == cl) begin
            fm = -cu - 1;
        end else begin
            own = (cu < cl) ? cu : cl;
            nei = (cu < cl) ? cl : cu;
            n = owner_cnt[own];
            f = n_cfaces;
            hit = 0;
            for (i = 0; i < n && !hit; i++) begin
                if (cf_neigh[owner_slot[own*N_NEIGH+i]] == nei) begin
                    f = owner_slot[own*N_NEIGH+i];
                    hit = 1;
                end
            end
            if (!hit) begin
                if (n >= N_NEIGH || n_cfaces >= N_CFACE) return cfa_pkg::ST_FULL;
                owner_slot[own*N_NEIGH+n] = f;
                owner_cnt[own] = n + 1;
                cf_neigh[f] = nei;
                cf_owner[f] = own;
                n_cfaces++;
            end
            fm = f;
            fl = (cu == own);
        end
        ff_map[n_ffaces] = fm;
        ff_flip[n_ffaces] = fl;
        n_ffaces++;
        return cfa_pkg::ST_OK;
    endfunction

    // renumber coarse faces owner by owner (upper-triangular order)
    function automatic void renumber();
        int k, c, i, s;
        int so [N_CFACE];
        int sn [N_CFACE];
        k = 0;
        for (c = 0; c < N_COARSE; c++) begin
            for (i = 0; i < owner_cnt[c]; i++) begin
                s = owner_slot[c*N_NEIGH+i];
                cf_final[s] = k;
                so[k] = c;
                sn[k] = cf_neigh[s];
                k++;
            end
        end
        for (i = 0; i < k; i++) begin
            cf_owner[i] = so[i];
            cf_neigh[i] = sn[i];
        end
        is_final = 1;
    endfunction

    function automatic t_reply predict_reply(t_word w);
        t_reply r;
        int fm;
        bit fl;
        r = '0;
        case (w.act)
            cfa_pkg::ACT_CLEAR: wipe_agglom();
            cfa_pkg::ACT_LOAD: begin
                if (is_final) r.status = cfa_pkg::ST_ORDER;
                else if (w.cc >= cell_lim()) r.status = cfa_pkg::ST_CELL;
                else begin
                    map_valid[w.fc] = 1;
                    map_coarse[w.fc] = w.cc;
                end
            end
            cfa_pkg::ACT_ADD: begin
                r.status = agglomerate(w.up, w.lo, fm, fl);
                if (r.status == cfa_pkg::ST_OK) begin
                    r.fmap = fm[13:0];
                    r.flip = fl;
                end
            end
            cfa_pkg::ACT_FIN: begin
                if (is_final) r.status = cfa_pkg::ST_ORDER;
                else renumber();
            end
            cfa_pkg::ACT_RDC: begin
                if (!is_final || w.idx >= n_cfaces) r.status = cfa_pkg::ST_ORDER;
                else begin
                    r.owner = cf_owner[w.idx][9:0];
                    r.neigh = cf_neigh[w.idx][9:0];
                end
            end
            cfa_pkg::ACT_RDF: begin
                if (!is_final || w.idx >= n_ffaces) r.status = cfa_pkg::ST_ORDER;
                else begin
                    fm = ff_map[w.idx];
                    if (fm >= 0) fm = cf_final[fm];
                    r.fmap = fm[13:0];
                    r.flip = ff_flip[w.idx];
                end
            end
            default: r.status = cfa_pkg::ST_ORDER;
        endcase
        r.count = n_cfaces[13:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driver: one word per handshake, random sender gaps.
    // ---------------------------------------------------------------
    task automatic send_word(t_word w, bit typed = 0, t_reply typed_r = '0);
        t_reply r;
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_action <= w.act;
        i_fine_cell <= w.fc;
        i_coarse_cell <= w.cc;
        i_upper_cell <= w.up;
        i_lower_cell <= w.lo;
        i_read_index <= w.idx;
        do @(posedge i_clk); while (busy);
        r = predict_reply(w);
        replies_due.push_back(typed ? typed_r : r);
        n_words++;
    endtask

    // drain all replies, then rewrite the coarse cell count
    task automatic set_ncc(int v);
        start <= 0;
        @(posedge i_clk);
        while (replies_due.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v[10:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        ncc_reg = v & 11'h7FF;
    endtask

    function automatic t_word mk(logic [2:0] a, int fc = 0, int cc = 0,
                                 int up = 0, int lo = 0, int idx = 0);
        t_word w;
        w.act = a;
        w.fc = fc[11:0];
        w.cc = cc[9:0];
        w.up = up[11:0];
        w.lo = lo[11:0];
        w.idx = idx[13:0];
        return w;
    endfunction

    // one build: clear, load map, add faces, finalize, read back
    task automatic run_session(int ncc);
        int cells[$];
        int nf, lim, a, b, k, n;
        set_ncc(ncc);
        send_word(mk(cfa_pkg::ACT_CLEAR));
        lim = cell_lim();
        nf = $urandom_range(4, 48);
        for (k = 0; k < nf; k++) begin
            a = $urandom_range(0, 4095);
            cells.push_back(a);
            b = ($urandom_range(11) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(0, lim - 1);
            send_word(mk(cfa_pkg::ACT_LOAD, a, b));
        end
        // sometimes shrink/grow the cell count so loaded entries fall out of range
        if ($urandom_range(3) == 0) begin
            set_ncc($urandom_range(1, 2047));
            lim = cell_lim();
        end
        // star of faces on one coarse owner, overflowing its neighbour list
        if (lim >= 18 && $urandom_range(2) == 0) begin
            a = $urandom_range(0, 4095);
            send_word(mk(cfa_pkg::ACT_LOAD, a, 0));
            for (k = 1; k <= 17; k++) begin
                b = $urandom_range(0, 4095);
                if (b != a) begin
                    send_word(mk(cfa_pkg::ACT_LOAD, b, k));
                    send_word(mk(cfa_pkg::ACT_ADD, 0, 0, a, b));
                end
            end
        end
        n = $urandom_range(10, 60);
        for (k = 0; k < n; k++) begin
            a = ($urandom_range(14) == 0) ? $urandom_range(0, 4095)
                                          : cells[$urandom_range(0, nf - 1)];
            b = ($urandom_range(14) == 0) ? $urandom_range(0, 4095)
                                          : cells[$urandom_range(0, nf - 1)];
            send_word(mk(cfa_pkg::ACT_ADD, 0, 0, a, b));
            if ($urandom_range(19) == 0)
                send_word(mk(3'($urandom_range(3, 7)), $urandom_range(0, 4095),
                             $urandom_range(0, 1023), 0, 0,
                             $urandom_range(0, 16383)));
        end
        send_word(mk(cfa_pkg::ACT_FIN));
        for (k = 0; k <= n_cfaces; k++)
            send_word(mk(cfa_pkg::ACT_RDC, 0, 0, 0, 0, k));
        for (k = 0; k <= n_ffaces; k++)
            send_word(mk(cfa_pkg::ACT_RDF, 0, 0, 0, 0, k));
        for (k = 0; k < 4; k++)
            send_word(mk(($urandom_range(0, 7) == 0) ? cfa_pkg::ACT_LOAD
                                                     : 3'($urandom_range(3, 7)),
                         $urandom_range(0, 4095), $urandom_range(0, 1023),
                         $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 16383)));
    endtask

    // ---------------------------------------------------------------
    // Directed table, run with the reset value of the cell count (1).
    // ---------------------------------------------------------------
    localparam t_reply R_ORDER0 = '{cfa_pkg::ST_ORDER, 14'd0, 10'd0, 10'd0, 14'd0, 1'b0};
    localparam t_reply R_CELL0  = '{cfa_pkg::ST_CELL,  14'd0, 10'd0, 10'd0, 14'd0, 1'b0};
    localparam t_reply R_OK0    = '{cfa_pkg::ST_OK,    14'd0, 10'd0, 10'd0, 14'd0, 1'b0};
    localparam t_reply R_INT0   = '{cfa_pkg::ST_OK,    14'd0, 10'd0, 10'd0, 14'h3FFF, 1'b0};

    t_row dir_rows [18];

    initial begin
        dir_rows = '{
            '{mk(cfa_pkg::ACT_RDC),                   1, R_ORDER0},  // read before finalize
            '{mk(ACT_BAD6),                           1, R_ORDER0},
            '{mk(ACT_BAD7, 4095, 1023, 4095, 4095, 16383), 1, R_ORDER0},
            '{mk(cfa_pkg::ACT_ADD, 0, 0, 0, 0),       1, R_CELL0},   // unmapped cells
            '{mk(cfa_pkg::ACT_LOAD, 4095, 0),         1, R_OK0},
            '{mk(cfa_pkg::ACT_LOAD, 0, 1023),         1, R_CELL0},   // coarse cell out of range
            '{mk(cfa_pkg::ACT_LOAD, 0, 0),            1, R_OK0},
            '{mk(cfa_pkg::ACT_ADD, 0, 0, 4095, 0),    1, R_INT0},    // internal face -> -1
            '{mk(cfa_pkg::ACT_ADD, 0, 0, 4095, 4095), 1, R_INT0},
            '{mk(cfa_pkg::ACT_RDF),                   1, R_ORDER0},
            '{mk(cfa_pkg::ACT_FIN),                   1, R_OK0},
            '{mk(cfa_pkg::ACT_LOAD, 1, 0),            1, R_ORDER0},  // load after finalize
            '{mk(cfa_pkg::ACT_ADD, 0, 0, 0, 0),       1, R_ORDER0},
            '{mk(cfa_pkg::ACT_FIN),                   1, R_ORDER0},
            '{mk(cfa_pkg::ACT_RDF, 0, 0, 0, 0, 1),    1, R_INT0},
            '{mk(cfa_pkg::ACT_RDF, 0, 0, 0, 0, 16383), 1, R_ORDER0}, // past fine face count
            '{mk(cfa_pkg::ACT_RDC, 0, 0, 0, 0, 0),    1, R_ORDER0},  // no coarse faces
            '{mk(cfa_pkg::ACT_CLEAR),                 1, R_OK0}
        };
    end

    // ---------------------------------------------------------------
    // Reply checker: every o_valid word against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && o_valid) begin
            if (replies_due.size() == 0) begin
                $error("unexpected reply word, status %0d", o_status);
                failed = 1;
            end else begin
                e = replies_due.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    failed = 1;
                end
                if (o_coarse_face_count !== e.count) begin
                    $error("coarse_face_count: expected %0d, got %0d",
                           e.count, o_coarse_face_count);
                    failed = 1;
                end
                if (o_face_owner !== e.owner) begin
                    $error("face_owner: expected %0d, got %0d", e.owner, o_face_owner);
                    failed = 1;
                end
                if (o_face_neighbour !== e.neigh) begin
                    $error("face_neighbour: expected %0d, got %0d",
                           e.neigh, o_face_neighbour);
                    failed = 1;
                end
                if (o_face_map !== e.fmap) begin
                    $error("face_map: expected %0d, got %0d",
                           $signed(e.fmap), o_face_map);
                    failed = 1;
                end
                if (o_flip !== e.flip) begin
                    $error("flip: expected %0d, got %0d", e.flip, o_flip);
                    failed = 1;
                end
            end
        end
    end

    // watchdog: cycles with neither an accepted word nor a reply
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int s, k;
        ncc_reg = 1;
        wipe_agglom();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (k = 0; k < 18; k++)
            send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].r);

        // random sessions; the cell count walks through its extremes
        s = 0;
        while (n_words < 2000) begin
            case (s % 4)
                0: idle_pct = 0;
                1: idle_pct = 65;
                2: idle_pct = 0;
                default: idle_pct = 11;
            endcase
            case (s % 6)
                0: run_session(1);
                1: run_session(1024);
                2: run_session(2047);
                3: run_session($urandom_range(18, 24));
                default: run_session($urandom_range(2, 40));
            endcase
            s++;
        end

        start <= 0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cfa_pkg.sv
rtl/cfa_ctrl.sv
rtl/cfa_datapath.sv
rtl/coarse_face_agglomerator_unit.sv
rtl/cfa_checker.sv
test/tb_top.sv
